// ===== hdl/sfb_pkg.sv =====
`default_nettype none

package sfb_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] STUFF_MASK = 8'h5F;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] chk;
    logic       first;
    logic       last;
    logic       seq;
  } job_t;

  function automatic logic needs_stuff(input logic [7:0] b);
    needs_stuff = (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sfb_front.sv =====
`default_nettype none

module sfb_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        seq_bit_i,
  output sfb_pkg::job_t    job_o
);

  logic [7:0] accum_q, accum_d;
  logic [7:0] chk_next;

  always_comb begin
    chk_next = (first_byte_i ? 8'h00 : accum_q) ^ data_byte_i;
    accum_d  = accum_q;
    if (accept_i) begin
      accum_d = last_byte_i ? 8'h00 : chk_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= 8'h00;
    end else begin
      accum_q <= accum_d;
    end
  end

  assign job_o.data  = data_byte_i;
  assign job_o.chk   = chk_next;
  assign job_o.first = first_byte_i;
  assign job_o.last  = last_byte_i;
  assign job_o.seq   = seq_bit_i;

  // check restarts clean after a closing word
  a_accum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> accum_q == 8'h00)
    else $error("check accumulator not cleared after last word");

endmodule

`default_nettype wire

// ===== hdl/sfb_queue.sv =====
`default_nettype none

module sfb_queue #(
  parameter int unsigned Depth = sfb_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sfb_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               head_valid_o,
  output sfb_pkg::job_t      head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sfb_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/sfb_back.sv =====
`default_nettype none

module sfb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    address_i,
  input  wire logic          job_valid_i,
  input  wire sfb_pkg::job_t job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               frame_end_o
);

  typedef enum logic [3:0] {
    ST_START,
    ST_FLAG_OPEN,
    ST_ADDR,
    ST_CTRL,
    ST_HCHK,
    ST_DATA,
    ST_DATA_STUFF,
    ST_CHK,
    ST_CHK_STUFF,
    ST_FLAG_CLOSE
  } step_e;

  step_e      step_q, cur_step, nxt_step;
  logic       out_valid_q;
  logic [7:0] out_byte_q, byte_d;
  logic       run_last_q, frame_end_q, frame_end_d;
  logic       done, adv;
  logic [7:0] ctrl;
  logic       stuff_data, stuff_chk;

  always_comb begin
    ctrl       = {job_i.seq, 7'b0};
    stuff_data = sfb_pkg::needs_stuff(job_i.data);
    stuff_chk  = sfb_pkg::needs_stuff(job_i.chk);
    if (step_q == ST_START) begin
      cur_step = job_i.first ? ST_FLAG_OPEN : ST_DATA;
    end else begin
      cur_step = step_q;
    end
    byte_d      = sfb_pkg::FLAG_BYTE;
    frame_end_d = 1'b0;
    done        = 1'b0;
    nxt_step    = ST_START;
    case (cur_step)
      ST_FLAG_OPEN: begin
        nxt_step = ST_ADDR;
      end
      ST_ADDR: begin
        byte_d   = address_i;
        nxt_step = ST_CTRL;
      end
      ST_CTRL: begin
        byte_d   = ctrl;
        nxt_step = ST_HCHK;
      end
      ST_HCHK: begin
        byte_d   = address_i ^ ctrl;
        nxt_step = ST_DATA;
      end
      ST_DATA: begin
        byte_d = stuff_data ? sfb_pkg::ESC_BYTE : job_i.data;
        if (stuff_data) begin
          nxt_step = ST_DATA_STUFF;
        end else if (job_i.last) begin
          nxt_step = ST_CHK;
        end else begin
          done = 1'b1;
        end
      end
      ST_DATA_STUFF: begin
        byte_d = job_i.data & sfb_pkg::STUFF_MASK;
        if (job_i.last) begin
          nxt_step = ST_CHK;
        end else begin
          done = 1'b1;
        end
      end
      ST_CHK: begin
        byte_d   = stuff_chk ? sfb_pkg::ESC_BYTE : job_i.chk;
        nxt_step = stuff_chk ? ST_CHK_STUFF : ST_FLAG_CLOSE;
      end
      ST_CHK_STUFF: begin
        byte_d   = job_i.chk & sfb_pkg::STUFF_MASK;
        nxt_step = ST_FLAG_CLOSE;
      end
      ST_FLAG_CLOSE: begin
        frame_end_d = 1'b1;
        done        = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    adv   = job_valid_i && (!out_valid_q || !out_stall_i);
    pop_o = adv && done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_START;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'h00;
      run_last_q  <= 1'b0;
      frame_end_q <= 1'b0;
    end else if (adv) begin
      step_q      <= done ? ST_START : nxt_step;
      out_valid_q <= 1'b1;
      out_byte_q  <= byte_d;
      run_last_q  <= done;
      frame_end_q <= frame_end_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

  a_close_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o && out_byte_o == sfb_pkg::FLAG_BYTE)
    else $error("closing flag malformed");

endmodule

`default_nettype wire

// ===== hdl/stuffed_frame_builder_top.sv =====
`default_nettype none

// path: an accepted input word goes through a queue entry, then the output register
// throughput: one input word per cycle into a two-entry job queue unless full; the
// output port sends one word per cycle unless stalled, from the single output
// register; an item yields 1 to 9 words (1 plain, 2 stuffed, up to 9 for a one-word frame)
// reset: queue empty, check cleared, address register set to 3, no clearing pass

module stuffed_frame_builder_top #(
  parameter int unsigned QueueDepth = sfb_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_address_byte_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        seq_bit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             frame_end_o
);

  logic [7:0]    address_q;
  logic          accept, full, pop, head_valid;
  sfb_pkg::job_t push_job, head_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= sfb_pkg::ADDR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      address_q <= cfg_address_byte_i;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .seq_bit_i    (seq_bit_i),
    .job_o        (push_job)
  );

  sfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  sfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .address_i   (address_q),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire
